// File: design/mqtt_rx_pkg.sv
package mqtt_rx_pkg;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam logic [3:0] KIND_CONNACK  = 4'd2;
	localparam logic [3:0] KIND_PUBLISH  = 4'd3;
	localparam logic [3:0] KIND_SUBACK   = 4'd9;
	localparam logic [3:0] KIND_PINGRESP = 4'd13;

	localparam logic [1:0] BK_NONE    = 2'd0;
	localparam logic [1:0] BK_TOPIC   = 2'd1;
	localparam logic [1:0] BK_PAYLOAD = 2'd2;
	localparam logic [1:0] BK_POP     = 2'd3;

	localparam logic [1:0] BAD_NONE      = 2'd0;
	localparam logic [1:0] BAD_MALFORMED = 2'd1;
	localparam logic [1:0] BAD_FULL      = 2'd2;

	localparam logic [2:0] ST_CONNACK  = 3'd3;
	localparam logic [2:0] ST_SUBACK   = 3'd4;
	localparam logic [2:0] ST_PINGRESP = 3'd5;
	localparam logic [2:0] ST_OTHER    = 3'd6;

	localparam logic [7:0] CONNACK_NONE = 8'hFF;
	localparam logic [15:0] POS_MAX     = 16'hFFFF;
	localparam logic [2:0] LEN_DIGITS_MAX = 3'd4;

	typedef struct packed {
		logic        push;
		logic        overflow_set;
		logic [15:0] id;
	} ring_req_t;

endpackage

// File: design/mqtt_rx_in_if.sv
interface mqtt_rx_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] rx_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, cmd, rx_byte, first_byte, last_byte, input ready);
	modport sink (input valid, cmd, rx_byte, first_byte, last_byte, output ready);
endinterface

// File: design/mqtt_rx_out_if.sv
interface mqtt_rx_out_if #(
	parameter int CNT_W = 4
);
	logic             valid;
	logic             ready;
	logic [1:0]       byte_kind;
	logic [7:0]       data_out;
	logic             packet_end;
	logic [2:0]       packet_status;
	logic [7:0]       connack_code;
	logic [1:0]       publish_qos;
	logic             ack_valid;
	logic [15:0]      ack_packet_id;
	logic [CNT_W-1:0] ack_count;
	logic             ack_overflow;

	modport source (output valid, byte_kind, data_out, packet_end, packet_status,
		connack_code, publish_qos, ack_valid, ack_packet_id, ack_count, ack_overflow,
		input ready);
	modport sink (input valid, byte_kind, data_out, packet_end, packet_status,
		connack_code, publish_qos, ack_valid, ack_packet_id, ack_count, ack_overflow,
		output ready);
endinterface

// File: design/mqtt_rx_ram.sv
module mqtt_rx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/mqtt_rx_parser.sv
module mqtt_rx_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  logic                  first_byte,
	input  logic                  last_byte,
	input  logic                  ring_full,
	output mqtt_rx_pkg::ring_req_t ring_req,
	output logic [1:0]            byte_kind,
	output logic [7:0]            data_out,
	output logic                  packet_end,
	output logic [2:0]            packet_status,
	output logic [7:0]            connack_code,
	output logic [1:0]            publish_qos
);
	import mqtt_rx_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_LEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_ID_HI, PH_ID_LO, PH_BODY
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  kind_q, kind_d;
	logic [1:0]  qos_q, qos_d;
	logic [2:0]  digits_q, digits_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] tsize_q, tsize_d;
	logic [7:0]  idhi_q, idhi_d;
	logic [7:0]  connack_q, connack_d;
	logic [1:0]  bad_q, bad_d;
	logic        open;
	phase_t      after_topic;

	assign after_topic = (qos_q != 2'd0) ? PH_ID_HI : PH_BODY;

	always_comb begin
		phase_d       = phase_q;
		kind_d        = kind_q;
		qos_d         = qos_q;
		digits_d      = digits_q;
		pos_d         = pos_q;
		tsize_d       = tsize_q;
		idhi_d        = idhi_q;
		connack_d     = connack_q;
		bad_d         = bad_q;
		open          = 1'b0;
		ring_req      = '0;
		byte_kind     = BK_NONE;
		packet_end    = 1'b0;
		packet_status = 3'd0;
		if (step) begin
			if (first_byte) begin
				open     = 1'b1;
				kind_d   = rx_byte[7:4];
				qos_d    = (rx_byte[7:4] == KIND_PUBLISH) ? rx_byte[2:1] : 2'd0;
				digits_d = 3'd0;
				pos_d    = 16'd0;
				tsize_d  = 16'd0;
				idhi_d   = 8'd0;
				bad_d    = BAD_NONE;
				if (rx_byte[7:4] == KIND_CONNACK) begin
					connack_d = CONNACK_NONE;
				end
				phase_d = (rx_byte[7:4] == KIND_PUBLISH) ? PH_LEN : PH_BODY;
			end else if (phase_q != PH_IDLE) begin
				open = 1'b1;
				if (pos_q != POS_MAX) begin
					pos_d = pos_q + 16'd1;
				end
				if (kind_q == KIND_CONNACK && pos_d == 16'd3) begin
					connack_d = rx_byte;
				end
				unique case (phase_q)
					PH_LEN: begin
						digits_d = digits_q + 3'd1;
						if (!rx_byte[7]) begin
							phase_d = PH_TLEN_HI;
						end else if (digits_d >= LEN_DIGITS_MAX) begin
							bad_d   = BAD_MALFORMED;
							phase_d = PH_BODY;
						end
					end
					PH_TLEN_HI: begin
						tsize_d = {rx_byte, 8'd0};
						phase_d = PH_TLEN_LO;
					end
					PH_TLEN_LO: begin
						tsize_d = {tsize_q[15:8], rx_byte};
						phase_d = (tsize_d != 16'd0) ? PH_TOPIC : after_topic;
					end
					PH_TOPIC: begin
						byte_kind = BK_TOPIC;
						tsize_d   = tsize_q - 16'd1;
						if (tsize_d == 16'd0) begin
							phase_d = after_topic;
						end
					end
					PH_ID_HI: begin
						idhi_d  = rx_byte;
						phase_d = PH_ID_LO;
					end
					PH_ID_LO: begin
						if (ring_full) begin
							ring_req.overflow_set = 1'b1;
							bad_d = BAD_FULL;
						end else begin
							ring_req.push = 1'b1;
							ring_req.id   = {idhi_q, rx_byte};
						end
						phase_d = PH_BODY;
					end
					PH_BODY, PH_IDLE: begin
						if (kind_q == KIND_PUBLISH && bad_q == BAD_NONE) begin
							byte_kind = BK_PAYLOAD;
						end
					end
				endcase
			end
			if (open && last_byte) begin
				if (kind_d == KIND_PUBLISH && bad_d == BAD_NONE && phase_d != PH_BODY) begin
					bad_d = BAD_MALFORMED;
				end
				packet_end = 1'b1;
				case (kind_d)
					KIND_PUBLISH:  packet_status = {1'b0, bad_d};
					KIND_CONNACK:  packet_status = ST_CONNACK;
					KIND_SUBACK:   packet_status = ST_SUBACK;
					KIND_PINGRESP: packet_status = ST_PINGRESP;
					default:       packet_status = ST_OTHER;
				endcase
				phase_d = PH_IDLE;
			end
		end
	end

	assign data_out     = (byte_kind == BK_TOPIC || byte_kind == BK_PAYLOAD) ? rx_byte : 8'd0;
	assign connack_code = connack_d;
	assign publish_qos  = (kind_d == KIND_PUBLISH) ? qos_d : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			kind_q    <= 4'd0;
			qos_q     <= 2'd0;
			digits_q  <= 3'd0;
			pos_q     <= 16'd0;
			tsize_q   <= 16'd0;
			idhi_q    <= 8'd0;
			connack_q <= CONNACK_NONE;
			bad_q     <= BAD_NONE;
		end else begin
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			qos_q     <= qos_d;
			digits_q  <= digits_d;
			pos_q     <= pos_d;
			tsize_q   <= tsize_d;
			idhi_q    <= idhi_d;
			connack_q <= connack_d;
			bad_q     <= bad_d;
		end
	end
endmodule

// File: design/mqtt_rx_ack_ring.sv
module mqtt_rx_ack_ring #(
	parameter int ACK_DEPTH = 8,
	parameter int PTR_W = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1,
	parameter int CNT_W = $clog2(ACK_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [1:0]            cmd,
	input  mqtt_rx_pkg::ring_req_t req,
	output logic                  full,
	output logic                  ack_valid,
	output logic [15:0]           ack_packet_id,
	output logic [CNT_W-1:0]      ack_count,
	output logic                  ack_overflow
);
	import mqtt_rx_pkg::*;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ACK_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ACK_DEPTH);

	logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             ovf_q, ovf_d;
	logic             we;
	logic [15:0]      rdata, head_id;
	logic             fwd_q;
	logic [15:0]      fwd_data_q;

	assign full    = count_q >= CNT_FULL;
	assign we      = step && cmd == CMD_BYTE && req.push;
	assign head_id = fwd_q ? fwd_data_q : rdata;

	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		count_d       = count_q;
		ovf_d         = ovf_q;
		ack_valid     = 1'b0;
		ack_packet_id = 16'd0;
		if (step) begin
			case (cmd)
				CMD_BYTE: begin
					if (req.push) begin
						head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
						count_d = count_q + 1'b1;
					end
					if (req.overflow_set) begin
						ovf_d = 1'b1;
					end
				end
				CMD_POP: begin
					if (count_q != '0) begin
						ack_valid     = 1'b1;
						ack_packet_id = head_id;
						tail_d        = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
						count_d       = count_q - 1'b1;
					end
				end
				CMD_CLEAR: begin
					head_d  = '0;
					tail_d  = '0;
					count_d = '0;
					ovf_d   = 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign ack_count    = count_d;
	assign ack_overflow = ovf_d;

	// read runs one step ahead at the next tail; same-edge write is forwarded
	mqtt_rx_ram #(.WIDTH(16), .DEPTH(ACK_DEPTH), .AW(PTR_W)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (head_q),
		.wdata (req.id),
		.raddr (tail_d),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		fwd_data_q <= req.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			fwd_q   <= we && head_q == tail_d;
		end
	end
endmodule

// File: design/mqtt_rx_packet_parser_unit.sv
// Receive-side MQTT 3.1.1 packet parser. Takes one command per transfer on rx_in
// (received byte with first/last marks, pop of a pending acknowledge id, or ring
// clear) and returns exactly one result per command on rx_out. A transfer is
// registered on input, parsed from that input register and held in the output
// register, so one command is accepted every cycle when rx_out is ready; either
// side may stall without loss. Packet ids of QoS 1/2 PUBLISH packets are queued
// in an ACK_DEPTH-entry RAM ring; ack_count is $clog2(ACK_DEPTH+1) bits wide and
// the rx_out interface must be built to match.
module mqtt_rx_packet_parser_unit #(
	parameter int ACK_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mqtt_rx_in_if.sink           rx_in,
	mqtt_rx_out_if.source        rx_out
);
	import mqtt_rx_pkg::*;

	localparam int PTR_W = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(ACK_DEPTH + 1);

	logic             valid_s1;
	logic [1:0]       cmd_s1;
	logic [7:0]       byte_s1;
	logic             first_s1, last_s1;
	logic             advance, step, in_xfer;
	ring_req_t        ring_req;
	logic             ring_full;

	logic [1:0]       byte_kind, byte_kind_p;
	logic [7:0]       data_out;
	logic             packet_end;
	logic [2:0]       packet_status;
	logic [7:0]       connack_code;
	logic [1:0]       publish_qos;
	logic             ack_valid;
	logic [15:0]      ack_packet_id;
	logic [CNT_W-1:0] ack_count;
	logic             ack_overflow;

	logic             valid_s2;
	logic [1:0]       byte_kind_s2;
	logic [7:0]       data_out_s2;
	logic             packet_end_s2;
	logic [2:0]       packet_status_s2;
	logic [7:0]       connack_code_s2;
	logic [1:0]       publish_qos_s2;
	logic             ack_valid_s2;
	logic [15:0]      ack_packet_id_s2;
	logic [CNT_W-1:0] ack_count_s2;
	logic             ack_overflow_s2;

	assign advance     = !valid_s2 || rx_out.ready;
	assign step        = valid_s1 && advance;
	assign rx_in.ready = !valid_s1 || advance;
	assign in_xfer     = rx_in.valid && rx_in.ready;

	mqtt_rx_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step && cmd_s1 == CMD_BYTE),
		.rx_byte       (byte_s1),
		.first_byte    (first_s1),
		.last_byte     (last_s1),
		.ring_full     (ring_full),
		.ring_req      (ring_req),
		.byte_kind     (byte_kind_p),
		.data_out      (data_out),
		.packet_end    (packet_end),
		.packet_status (packet_status),
		.connack_code  (connack_code),
		.publish_qos   (publish_qos)
	);

	mqtt_rx_ack_ring #(.ACK_DEPTH(ACK_DEPTH), .PTR_W(PTR_W), .CNT_W(CNT_W)) u_ring (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cmd           (cmd_s1),
		.req           (ring_req),
		.full          (ring_full),
		.ack_valid     (ack_valid),
		.ack_packet_id (ack_packet_id),
		.ack_count     (ack_count),
		.ack_overflow  (ack_overflow)
	);

	assign byte_kind = (cmd_s1 == CMD_POP) ? BK_POP : byte_kind_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1   <= rx_in.cmd;
			byte_s1  <= rx_in.rx_byte;
			first_s1 <= rx_in.first_byte;
			last_s1  <= rx_in.last_byte;
		end
		if (step) begin
			byte_kind_s2     <= byte_kind;
			data_out_s2      <= data_out;
			packet_end_s2    <= packet_end;
			packet_status_s2 <= packet_status;
			connack_code_s2  <= connack_code;
			publish_qos_s2   <= publish_qos;
			ack_valid_s2     <= ack_valid;
			ack_packet_id_s2 <= ack_packet_id;
			ack_count_s2     <= ack_count;
			ack_overflow_s2  <= ack_overflow;
		end
	end

	assign rx_out.valid         = valid_s2;
	assign rx_out.byte_kind     = byte_kind_s2;
	assign rx_out.data_out      = data_out_s2;
	assign rx_out.packet_end    = packet_end_s2;
	assign rx_out.packet_status = packet_status_s2;
	assign rx_out.connack_code  = connack_code_s2;
	assign rx_out.publish_qos   = publish_qos_s2;
	assign rx_out.ack_valid     = ack_valid_s2;
	assign rx_out.ack_packet_id = ack_packet_id_s2;
	assign rx_out.ack_count     = ack_count_s2;
	assign rx_out.ack_overflow  = ack_overflow_s2;

	a_pop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ack_valid_s2 |-> byte_kind_s2 == BK_POP)
		else $error("ack id reported outside a pop result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ack_count_s2 <= CNT_W'(ACK_DEPTH))
		else $error("ack ring count above depth");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1) && $stable(byte_s1))
		else $error("input stage lost a stalled transfer");

	a_end_idle_pop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && packet_end_s2 |-> byte_kind_s2 != BK_POP && !ack_valid_s2)
		else $error("packet end on a non-byte command");
endmodule
